@@ rtl/msms_pkg.sv @@
// shared types and constants of the magnet-stop motor sequencer
// field widths, mode codes, register indexes, reset values and blink divider
// no dependencies
`default_nettype none

package msms_pkg;

  localparam int NOW_W       = 32;
  localparam int SAMPLE_W    = 12;
  localparam int SPEED_W     = 9;
  localparam int DELAY_W     = 16;
  localparam int LIGHT_W     = 8;
  localparam int MODE_W      = 3;
  localparam int MAX_SAMPLES = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;

  localparam logic [MODE_W-1:0] MODE_STOPPED  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STARTING = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVING   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BRAKING  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BACKUP   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_LEVEL     = 3'd0,
    CFG_WINDOW_HALF    = 3'd1,
    CFG_FULL_SPEED     = 3'd2,
    CFG_BACKUP_SPEED   = 3'd3,
    CFG_START_DELAY    = 3'd4,
    CFG_BRAKE_SETTLE   = 3'd5,
    CFG_BACKUP_TIMEOUT = 3'd6,
    CFG_LIGHT_ON       = 3'd7
  } cfg_reg_t;

  localparam logic [SAMPLE_W-1:0]       BASE_LEVEL_RST     = 12'd1648;
  localparam logic [SAMPLE_W-1:0]       WINDOW_HALF_RST    = 12'd24;
  localparam logic signed [SPEED_W-1:0] FULL_SPEED_RST     = 9'sd200;
  localparam logic signed [SPEED_W-1:0] BACKUP_SPEED_RST   = -9'sd64;
  localparam logic [DELAY_W-1:0]        START_DELAY_RST    = 16'd500;
  localparam logic [DELAY_W-1:0]        BRAKE_SETTLE_RST   = 16'd500;
  localparam logic [DELAY_W-1:0]        BACKUP_TIMEOUT_RST = 16'd3000;
  localparam logic [LIGHT_W-1:0]        LIGHT_ON_RST       = 8'd25;

  // blink half period 300 ms: drop two bits, then divide by 75 through a reciprocal
  // ceil(2^37 / 75), exact for every 30-bit dividend
  localparam int              BLINK_PRE_SHIFT = 2;
  localparam int              BLINK_DIV_W     = NOW_W - BLINK_PRE_SHIFT;
  localparam int              BLINK_RECIP_W   = 31;
  localparam logic [30:0]     BLINK_RECIP     = 31'd1832519380;
  localparam int              BLINK_PROD_W    = BLINK_DIV_W + BLINK_RECIP_W;
  localparam int              BLINK_Q_LSB     = 37;

  typedef struct packed {
    logic all_on;
    logic all_off;
  } sense_t;

endpackage

`default_nettype wire

@@ rtl/msms_sense.sv @@
// window comparison of the field-sensor samples of one tick
// depends on msms_pkg
`default_nettype none

module msms_sense #(
  parameter int N_SAMPLES = 4
) (
  input  logic [msms_pkg::MAX_SAMPLES*msms_pkg::SAMPLE_W-1:0] samples,
  input  logic [msms_pkg::SAMPLE_W-1:0]                       base_level,
  input  logic [msms_pkg::SAMPLE_W-1:0]                       window_half,
  output msms_pkg::sense_t                                    sense
);
  import msms_pkg::*;

  localparam int NUSED = (N_SAMPLES < 1) ? 1 :
                         (N_SAMPLES > MAX_SAMPLES) ? MAX_SAMPLES : N_SAMPLES;

  logic signed [SAMPLE_W+1:0] low_bound;
  logic        [SAMPLE_W:0]   high_bound;
  logic        [MAX_SAMPLES-1:0] hit;

  assign low_bound  = $signed({2'b00, base_level}) - $signed({2'b00, window_half});
  assign high_bound = {1'b0, base_level} + {1'b0, window_half};

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_lane
    logic [SAMPLE_W-1:0] v;
    assign v      = samples[i*SAMPLE_W +: SAMPLE_W];
    assign hit[i] = ($signed({2'b00, v}) <= low_bound) || ({1'b0, v} >= high_bound);
  end

  always_comb begin
    sense.all_on  = 1'b1;
    sense.all_off = 1'b1;
    for (int i = 0; i < NUSED; i++) begin
      if (hit[i]) sense.all_off = 1'b0;
      else        sense.all_on  = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/magnet_stop_motor_sequencer_top.sv @@
// top level of the magnet-stop motor sequencer: beat registers, mode sequencer, blink timer
// depends on msms_pkg and msms_sense
`default_nettype none

// One tick beat is taken every cycle, unless the result side stalls, and gives one result
// beat. A tick passes three registers: the input register, the decision register (where
// the mode, entry time, drive and brake are updated, so the next tick sees them) and the
// result register, where the error blink phase is taken from one multiplier on the
// elapsed time. A stalled result side fills the three registers and then holds off new
// ticks. Configuration writes are always taken and must only be made while no tick is in
// flight.
module magnet_stop_motor_sequencer_top #(
  parameter int SAMPLES_PER_TICK = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // now_ms[31:0], sample_a[43:32], sample_b[55:44], sample_c[67:56], sample_d[79:68]
  input  logic [msms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // motor_speed[8:0], motor_brake[9], light_level[17:10], mode[20:18], mode_changed[21]
  output logic [msms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [msms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msms_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import msms_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    ST_STOPPED  = MODE_STOPPED,
    ST_STARTING = MODE_STARTING,
    ST_MOVING   = MODE_MOVING,
    ST_BRAKING  = MODE_BRAKING,
    ST_BACKUP   = MODE_BACKUP,
    ST_ERROR    = MODE_ERROR
  } mode_t;

  // configuration
  logic        [SAMPLE_W-1:0] base_level;
  logic        [SAMPLE_W-1:0] window_half;
  logic signed [SPEED_W-1:0]  full_speed;
  logic signed [SPEED_W-1:0]  backup_speed;
  logic        [DELAY_W-1:0]  start_delay_ms;
  logic        [DELAY_W-1:0]  brake_settle_ms;
  logic        [DELAY_W-1:0]  backup_timeout_ms;
  logic        [LIGHT_W-1:0]  light_on_level;

  // input register
  logic                                in_valid;
  logic [NOW_W-1:0]                    in_now;
  logic [MAX_SAMPLES*SAMPLE_W-1:0]     in_samples;

  // sequencer state
  mode_t                     mode;
  logic [NOW_W-1:0]          entry_time;
  logic signed [SPEED_W-1:0] drive_value;
  logic                      brake_held;

  // decision register
  logic                      mid_valid;
  logic signed [SPEED_W-1:0] mid_speed;
  logic                      mid_brake;
  logic [MODE_W-1:0]         mid_mode;
  logic                      mid_changed;
  logic                      mid_err;
  logic [NOW_W-1:0]          mid_elapsed;

  // result register
  logic                        out_valid;
  logic [OUT_TDATA_W-1:0]      out_data;

  logic                      in_ready;
  logic                      mid_ready;
  logic                      out_ready;
  logic                      advance;
  sense_t                    sense;
  logic [NOW_W-1:0]          elapsed;
  mode_t                     mode_next;
  logic signed [SPEED_W-1:0] drive_next;
  logic                      brake_next;
  logic [BLINK_PROD_W-1:0]   blink_prod;
  logic [LIGHT_W-1:0]        light;

  assign out_ready = !out_valid || m_axis_tready;
  assign mid_ready = !mid_valid || out_ready;
  assign in_ready  = !in_valid || mid_ready;
  assign advance   = in_valid && mid_ready;

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign cfg_ready     = 1'b1;

  msms_sense #(
    .N_SAMPLES (SAMPLES_PER_TICK)
  ) u_sense (
    .samples     (in_samples),
    .base_level  (base_level),
    .window_half (window_half),
    .sense       (sense)
  );

  assign elapsed = in_now - entry_time;

  always_comb begin
    mode_next  = mode;
    drive_next = drive_value;
    brake_next = brake_held;
    unique case (mode)
      ST_STARTING: begin
        if (elapsed > {{(NOW_W-DELAY_W){1'b0}}, start_delay_ms}) mode_next = ST_MOVING;
      end
      ST_MOVING: begin
        if (sense.all_on) begin
          brake_next = 1'b1;
          mode_next  = ST_BRAKING;
        end
      end
      ST_BRAKING: begin
        if (sense.all_off) begin
          drive_next = backup_speed;
          brake_next = 1'b0;
          mode_next  = ST_BACKUP;
        end else if (elapsed > {{(NOW_W-DELAY_W){1'b0}}, brake_settle_ms}) begin
          mode_next = ST_STOPPED;
        end
      end
      ST_BACKUP: begin
        if (sense.all_on) begin
          brake_next = 1'b1;
          mode_next  = ST_STOPPED;
        end else if (elapsed > {{(NOW_W-DELAY_W){1'b0}}, backup_timeout_ms}) begin
          brake_next = 1'b1;
          mode_next  = ST_ERROR;
        end
      end
      ST_STOPPED: begin
        if (sense.all_off) begin
          drive_next = full_speed;
          brake_next = 1'b0;
          mode_next  = ST_STARTING;
        end
      end
      default: begin
      end
    endcase
  end

  // bit BLINK_Q_LSB of the product is the lowest bit of elapsed / 300
  assign blink_prod = BLINK_PROD_W'(mid_elapsed[NOW_W-1:BLINK_PRE_SHIFT])
                    * BLINK_PROD_W'(BLINK_RECIP);
  assign light      = (mid_err && blink_prod[BLINK_Q_LSB]) ? '0 : light_on_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_level        <= BASE_LEVEL_RST;
      window_half       <= WINDOW_HALF_RST;
      full_speed        <= FULL_SPEED_RST;
      backup_speed      <= BACKUP_SPEED_RST;
      start_delay_ms    <= START_DELAY_RST;
      brake_settle_ms   <= BRAKE_SETTLE_RST;
      backup_timeout_ms <= BACKUP_TIMEOUT_RST;
      light_on_level    <= LIGHT_ON_RST;
      in_valid          <= 1'b0;
      mid_valid         <= 1'b0;
      out_valid         <= 1'b0;
      mode              <= ST_STARTING;
      entry_time        <= '0;
      drive_value       <= FULL_SPEED_RST;
      brake_held        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_BASE_LEVEL:     base_level        <= cfg_data[SAMPLE_W-1:0];
          CFG_WINDOW_HALF:    window_half       <= cfg_data[SAMPLE_W-1:0];
          CFG_FULL_SPEED:     full_speed        <= $signed(cfg_data[SPEED_W-1:0]);
          CFG_BACKUP_SPEED:   backup_speed      <= $signed(cfg_data[SPEED_W-1:0]);
          CFG_START_DELAY:    start_delay_ms    <= cfg_data[DELAY_W-1:0];
          CFG_BRAKE_SETTLE:   brake_settle_ms   <= cfg_data[DELAY_W-1:0];
          CFG_BACKUP_TIMEOUT: backup_timeout_ms <= cfg_data[DELAY_W-1:0];
          CFG_LIGHT_ON:       light_on_level    <= cfg_data[LIGHT_W-1:0];
          default: begin
          end
        endcase
      end

      if (in_ready) begin
        in_valid <= s_axis_tvalid;
        if (s_axis_tvalid) begin
          in_now     <= s_axis_tdata[NOW_W-1:0];
          in_samples <= s_axis_tdata[IN_TDATA_W-1:NOW_W];
        end
      end

      if (mid_ready) begin
        mid_valid <= in_valid;
      end
      if (advance) begin
        mode        <= mode_next;
        drive_value <= drive_next;
        brake_held  <= brake_next;
        if (mode_next != mode) entry_time <= in_now;
        mid_speed   <= brake_next ? '0 : drive_next;
        mid_brake   <= brake_next;
        mid_mode    <= mode_next;
        mid_changed <= (mode_next != mode);
        mid_err     <= (mode == ST_ERROR);
        mid_elapsed <= elapsed;
      end

      if (out_ready) begin
        out_valid <= mid_valid;
        if (mid_valid) begin
          out_data <= {2'b00, mid_changed, mid_mode, light, mid_brake, mid_speed};
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/msms_check.sv @@
// port-level checks of the magnet-stop motor sequencer, bound to the top level
// depends on msms_pkg and magnet_stop_motor_sequencer_top
`default_nettype none

module msms_check (
  input logic                             clk,
  input logic                             rst,
  input logic [msms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);
  import msms_pkg::*;

  logic [MODE_W-1:0] out_mode;
  logic              out_brake;

  assign out_mode  = m_axis_tdata[20:18];
  assign out_brake = m_axis_tdata[9];

  // brake is held exactly in stopped, braking and error
  a_brake_mode: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_brake == (out_mode == MODE_STOPPED ||
                                    out_mode == MODE_BRAKING ||
                                    out_mode == MODE_ERROR))
    else $error("brake does not match mode");

  a_brake_speed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_brake |-> m_axis_tdata[8:0] == '0)
    else $error("drive while brake held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

endmodule

bind magnet_stop_motor_sequencer_top msms_check u_check (.*);

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for magnet_stop_motor_sequencer_top: drives tick beats and
// register writes, predicts every result beat in-line and checks the output stream
// depends on msms_pkg and magnet_stop_motor_sequencer_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msms_pkg::*;

  localparam int          SENSORS       = 4;
  localparam logic [31:0] BLINK_HALF_MS = 32'd300;
  localparam int          DRAIN_CYCLES  = 6;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          HOLD_CYCLES   = 400;

  typedef enum int {TK_SENSED, TK_CLEAR, TK_MIXED, TK_NOISE} tick_kind_t;

  // packed from the top bit down, so the lowest field is declared last
  typedef struct packed {
    logic                changed;
    logic [MODE_W-1:0]   mode;
    logic [LIGHT_W-1:0]  light;
    logic                brake;
    logic signed [8:0]   speed;
  } motor_out_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // register copy
  logic [SAMPLE_W-1:0]       base_lvl   = BASE_LEVEL_RST;
  logic [SAMPLE_W-1:0]       win_half   = WINDOW_HALF_RST;
  logic signed [SPEED_W-1:0] full_spd   = FULL_SPEED_RST;
  logic signed [SPEED_W-1:0] backup_spd = BACKUP_SPEED_RST;
  logic [DELAY_W-1:0]        start_dly  = START_DELAY_RST;
  logic [DELAY_W-1:0]        settle_dly = BRAKE_SETTLE_RST;
  logic [DELAY_W-1:0]        backup_tmo = BACKUP_TIMEOUT_RST;
  logic [LIGHT_W-1:0]        light_on   = LIGHT_ON_RST;

  // sequencer copy
  logic [MODE_W-1:0]         seq_mode  = MODE_STARTING;
  logic [NOW_W-1:0]          seq_entry = '0;
  logic signed [SPEED_W-1:0] seq_drive = FULL_SPEED_RST;
  logic                      seq_brake = 1'b0;
  logic [7:0]                mode_seen = '0;

  motor_out_t       expected_outputs[$];
  logic [NOW_W-1:0] now_ts = '0;
  int ticks_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int rx_hold = 0;
  int rx_pause = 0;
  bit rx_steady = 0;
  bit tx_steady = 0;
  bit tx_pin_steady = 0;

  always #5 clk = ~clk;

  magnet_stop_motor_sequencer_top #(.SAMPLES_PER_TICK(SENSORS)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  task automatic report_fail(string msg);
    fail_count++;
    if (fail_count <= 40) $display("%s", msg);
  endtask

  function automatic logic is_magnet(logic [SAMPLE_W-1:0] v);
    int lo;
    int hi;
    lo = int'(base_lvl) - int'(win_half);
    hi = int'(base_lvl) + int'(win_half);
    return (int'(v) <= lo) || (int'(v) >= hi);
  endfunction

  function automatic motor_out_t advance_sequencer(logic [NOW_W-1:0] now,
                                                   logic [4*SAMPLE_W-1:0] smp);
    logic [NOW_W-1:0]   elapsed;
    logic [NOW_W-1:0]   blink_q;
    logic [MODE_W-1:0]  nxt;
    logic [LIGHT_W-1:0] lamp;
    logic               sensed;
    logic               clear;
    motor_out_t         r;
    elapsed = now - seq_entry;
    nxt = seq_mode;
    lamp = light_on;
    sensed = 1'b1;
    clear = 1'b1;
    for (int i = 0; i < SENSORS; i++) begin
      if (is_magnet(smp[SAMPLE_W*i +: SAMPLE_W])) clear = 1'b0;
      else sensed = 1'b0;
    end
    case (seq_mode)
      MODE_STARTING: begin
        if (elapsed > start_dly) nxt = MODE_MOVING;
      end
      MODE_MOVING: begin
        if (sensed) begin
          seq_brake = 1'b1;
          nxt = MODE_BRAKING;
        end
      end
      MODE_BRAKING: begin
        if (clear) begin
          seq_drive = backup_spd;
          seq_brake = 1'b0;
          nxt = MODE_BACKUP;
        end else if (elapsed > settle_dly) begin
          nxt = MODE_STOPPED;
        end
      end
      MODE_BACKUP: begin
        if (sensed) begin
          seq_brake = 1'b1;
          nxt = MODE_STOPPED;
        end else if (elapsed > backup_tmo) begin
          seq_brake = 1'b1;
          nxt = MODE_ERROR;
        end
      end
      MODE_STOPPED: begin
        if (clear) begin
          seq_drive = full_spd;
          seq_brake = 1'b0;
          nxt = MODE_STARTING;
        end
      end
      MODE_ERROR: begin
        blink_q = elapsed / BLINK_HALF_MS;
        if (blink_q[0]) lamp = '0;
      end
      default: ;
    endcase
    r.changed = (nxt != seq_mode);
    if (r.changed) begin
      seq_mode = nxt;
      seq_entry = now;
    end
    mode_seen[seq_mode] = 1'b1;
    r.speed = seq_brake ? '0 : seq_drive;
    r.brake = seq_brake;
    r.light = lamp;
    r.mode = seq_mode;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(bit magnet);
    int lo;
    int hi;
    int c_lo;
    int c_hi;
    int r;
    lo = int'(base_lvl) - int'(win_half);
    hi = int'(base_lvl) + int'(win_half);
    r = $urandom_range(0, 3);
    if (magnet) begin
      if (lo >= 0 && (hi > 4095 || $urandom_range(0, 1) == 0))
        return (r == 0) ? SAMPLE_W'(lo) : SAMPLE_W'($urandom_range(0, lo));
      if (hi <= 4095)
        return (r == 0) ? SAMPLE_W'(hi) : SAMPLE_W'($urandom_range(hi, 4095));
      return SAMPLE_W'($urandom_range(0, 4095));
    end
    c_lo = (lo + 1 < 0) ? 0 : lo + 1;
    c_hi = (hi - 1 > 4095) ? 4095 : hi - 1;
    if (c_lo > c_hi) return SAMPLE_W'($urandom_range(0, 4095));
    if (r == 0) return SAMPLE_W'(c_lo);
    if (r == 1) return SAMPLE_W'(c_hi);
    return SAMPLE_W'($urandom_range(c_lo, c_hi));
  endfunction

  // result side: check each beat against the oldest prediction
  always @(posedge clk) begin
    motor_out_t got;
    motor_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(motor_out_t)-1:0];
      results_seen++;
      if (expected_outputs.size() == 0) begin
        report_fail($sformatf("beat %0d: result with nothing expected", results_seen));
      end else begin
        want = expected_outputs.pop_front();
        if (got.speed !== want.speed)
          report_fail($sformatf("beat %0d: motor_speed expected %0d got %0d",
                                results_seen, want.speed, got.speed));
        if (got.brake !== want.brake)
          report_fail($sformatf("beat %0d: motor_brake expected %0d got %0d",
                                results_seen, want.brake, got.brake));
        if (got.light !== want.light)
          report_fail($sformatf("beat %0d: light_level expected %0d got %0d",
                                results_seen, want.light, got.light));
        if (got.mode !== want.mode)
          report_fail($sformatf("beat %0d: mode expected %0d got %0d",
                                results_seen, want.mode, got.mode));
        if (got.changed !== want.changed)
          report_fail($sformatf("beat %0d: mode_changed expected %0d got %0d",
                                results_seen, want.changed, got.changed));
      end
      if (results_seen % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      rx_pause = rx_steady ? 0 : $urandom_range(0, 16);
    end
  end

  // result side pacing, long hold-off included
  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_pause > 0) begin
        m_axis_tready <= 1'b0;
        rx_pause--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no beat moved for %0d cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_tick(logic [NOW_W-1:0] now, logic [4*SAMPLE_W-1:0] smp);
    int gap;
    if (ticks_sent % 48 == 0) tx_steady = ($urandom_range(0, 3) == 0);
    gap = (tx_steady || tx_pin_steady) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {smp, now};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_outputs.push_back(advance_sequencer(now, smp));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic random_tick(bit allow_error);
    int               r;
    int               span;
    logic [NOW_W-1:0] step;
    logic [NOW_W-1:0] cur_el;
    logic [4*SAMPLE_W-1:0] smp;
    tick_kind_t       kind;
    case (seq_mode)
      MODE_STARTING: span = start_dly;
      MODE_BRAKING:  span = settle_dly;
      MODE_BACKUP:   span = backup_tmo;
      MODE_ERROR:    span = 2 * BLINK_HALF_MS;
      default:       span = 40;
    endcase
    r = $urandom_range(0, 99);
    if (r < 40) step = $urandom_range(0, 4);
    else if (r < 85) step = $urandom_range(0, span + span / 2 + 2);
    else if (r < 96) step = $urandom_range(0, 3 * span + 20);
    else step = $urandom();
    r = $urandom_range(0, 99);
    kind = (r < 35) ? TK_SENSED : (r < 70) ? TK_CLEAR : (r < 90) ? TK_MIXED : TK_NOISE;
    // keep out of the error mode, which only reset leaves
    if (seq_mode == MODE_BACKUP && !allow_error) begin
      cur_el = now_ts - seq_entry;
      if (cur_el >= backup_tmo) begin
        step = '0;
        if (cur_el > backup_tmo) kind = TK_SENSED;
      end else if (step > backup_tmo - cur_el) begin
        step = backup_tmo - cur_el;
      end
    end
    now_ts = now_ts + step;
    for (int i = 0; i < 4; i++) begin
      case (kind)
        TK_SENSED: smp[SAMPLE_W*i +: SAMPLE_W] = pick_sample(1'b1);
        TK_CLEAR:  smp[SAMPLE_W*i +: SAMPLE_W] = pick_sample(1'b0);
        TK_MIXED:  smp[SAMPLE_W*i +: SAMPLE_W] = pick_sample($urandom_range(0, 1));
        default:   smp[SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'($urandom_range(0, 4095));
      endcase
    end
    send_tick(now_ts, smp);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE_LEVEL:     base_lvl = val[SAMPLE_W-1:0];
      CFG_WINDOW_HALF:    win_half = val[SAMPLE_W-1:0];
      CFG_FULL_SPEED:     full_spd = val[SPEED_W-1:0];
      CFG_BACKUP_SPEED:   backup_spd = val[SPEED_W-1:0];
      CFG_START_DELAY:    start_dly = val;
      CFG_BRAKE_SETTLE:   settle_dly = val;
      CFG_BACKUP_TIMEOUT: backup_tmo = val;
      CFG_LIGHT_ON:       light_on = val[LIGHT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_all(int base, int half, int full, int back, int sd, int bs, int bt,
                         int lamp);
    go_idle();
    write_reg(CFG_BASE_LEVEL, CFG_DATA_W'(base));
    write_reg(CFG_WINDOW_HALF, CFG_DATA_W'(half));
    write_reg(CFG_FULL_SPEED, CFG_DATA_W'(full));
    write_reg(CFG_BACKUP_SPEED, CFG_DATA_W'(back));
    write_reg(CFG_START_DELAY, CFG_DATA_W'(sd));
    write_reg(CFG_BRAKE_SETTLE, CFG_DATA_W'(bs));
    write_reg(CFG_BACKUP_TIMEOUT, CFG_DATA_W'(bt));
    write_reg(CFG_LIGHT_ON, CFG_DATA_W'(lamp));
  endtask

  // walk the whole cycle on reset settings, window edges and a timestamp wrap
  task automatic test_directed();
    send_tick(32'd0,          {4{12'd1648}});
    send_tick(32'd500,        {4{12'd0}});
    send_tick(32'd501,        {4{12'd4095}});
    send_tick(32'd502,        {4{12'd1648}});
    send_tick(32'd503,        {12'd0, 12'd4095, 12'd1624, 12'd1672});
    send_tick(32'd504,        {12'd1660, 12'd1648, 12'd1625, 12'd1671});
    send_tick(32'd505,        {12'd1648, 12'd1648, 12'd1648, 12'd0});
    send_tick(32'd3504,       {12'd0, 12'd1648, 12'd1648, 12'd1648});
    send_tick(32'd3506,       {4{12'd1624}});
    send_tick(32'd3507,       {12'd1648, 12'd1648, 12'd4095, 12'd1648});
    send_tick(32'd3508,       {4{12'd1648}});
    send_tick(32'hFFFF_FFF0,  {4{12'd1648}});
    send_tick(32'hFFFF_FFF1,  {4{12'd1672}});
    send_tick(32'h0000_01E1,  {12'd1648, 12'd0, 12'd1648, 12'd1648});
    send_tick(32'h0000_01E6,  {12'd1648, 12'd1648, 12'd4095, 12'd1648});
    send_tick(32'h0000_01E7,  {4{12'd1648}});
    send_tick(32'hFFFF_FFFF,  {4{12'd4095}});
    now_ts = 32'hFFFF_FFFF;
  endtask

  task automatic test_zero_window();
    set_all(1648, 0, 255, -255, 0, 0, 65535, 255);
    repeat (60) random_tick(1'b0);
  endtask

  task automatic test_window_beyond_scale();
    set_all(0, 4095, -255, 255, 10, 10, 65535, 0);
    repeat (60) random_tick(1'b0);
    set_all(4095, 4095, 1, -1, 65535, 65535, 65535, 128);
    repeat (60) random_tick(1'b0);
  endtask

  task automatic test_random_settings();
    int dly[2];
    int r;
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 2; j++) begin
        r = $urandom_range(0, 5);
        dly[j] = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 300);
      end
      r = $urandom_range(0, 3);
      set_all($urandom_range(0, 4095),
              (k % 3 == 0) ? $urandom_range(0, 4095) : $urandom_range(1, 300),
              int'($urandom_range(0, 510)) - 255, int'($urandom_range(0, 510)) - 255,
              dly[0], dly[1], 65535,
              (r == 0) ? 0 : (r == 1) ? 255 : $urandom_range(0, 255));
      repeat (100) random_tick(1'b0);
    end
  endtask

  // result side held off while ticks keep coming, so the input must stall
  task automatic test_input_stall();
    set_all(2048, 100, 100, -100, 5, 5, 65535, 200);
    tx_pin_steady = 1;
    rx_hold = HOLD_CYCLES;
    repeat (60) random_tick(1'b0);
    tx_pin_steady = 0;
  endtask

  task automatic test_error_mode();
    int tries;
    set_all(1648, 24, 200, -64, 0, 0, 0, 255);
    tries = 0;
    while (seq_mode != MODE_ERROR && tries < 3000) begin
      random_tick(1'b1);
      tries++;
    end
    repeat (150) random_tick(1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_window();
    test_window_beyond_scale();
    test_random_settings();
    test_input_stall();
    test_error_mode();
    go_idle();
    repeat (10) @(negedge clk);
    if (expected_outputs.size() != 0)
      report_fail($sformatf("%0d results never arrived", expected_outputs.size()));
    $display("sent %0d ticks over %0d register writes, checked %0d result beats",
             ticks_sent, cfg_writes, results_seen);
    $display("modes reached (bit per mode code): %b, mismatches: %0d", mode_seen[5:0],
             fail_count);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
